FILE: design/cft_pkg.sv
// ----------------------------------------------------------------------------
// cft_pkg
// Shared types and constants of the CSV field tokenizer.
// ----------------------------------------------------------------------------
package cft_pkg;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_NL    = 8'h0A;

  localparam logic [31:0] ROW_COUNT_MAX = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    MODE_START  = 2'd0,
    MODE_PLAIN  = 2'd1,
    MODE_QUOTED = 2'd2,
    MODE_QSEEN  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_QUOTE = 2'd1,
    ST_TOO_FEW   = 2'd2,
    ST_TOO_MANY  = 2'd3
  } status_t;

  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_END  = 1'b1;

  typedef struct packed {
    mode_t       scan_mode;
    logic        at_row_start;
    logic [15:0] field_index;
    logic [31:0] row_count;
    status_t     error_code;
  } parse_state_t;

  typedef struct packed {
    logic        has_byte;
    logic [7:0]  out_byte;
    logic        field_end;
    logic        row_end;
    logic [15:0] field_number;
    logic [31:0] rows_done;
    logic [1:0]  status;
    logic        done_res;
  } result_t;

endpackage

FILE: design/cft_if.sv
// ----------------------------------------------------------------------------
// cft_in_if / cft_out_if
// Valid/ready channels of the CSV field tokenizer.
// ----------------------------------------------------------------------------
interface cft_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] data_byte;

  modport source (output valid, output func, output data_byte, input ready);
  modport sink   (input valid, input func, input data_byte, output ready);
endinterface

interface cft_out_if;
  logic        valid;
  logic        ready;
  logic        has_byte;
  logic [7:0]  out_byte;
  logic        field_end;
  logic        row_end;
  logic [15:0] field_number;
  logic [31:0] rows_done;
  logic [1:0]  status;
  logic        done_res;

  modport source (output valid, output has_byte, output out_byte, output field_end,
                  output row_end, output field_number, output rows_done,
                  output status, output done_res, input ready);
  modport sink   (input valid, input has_byte, input out_byte, input field_end,
                  input row_end, input field_number, input rows_done,
                  input status, input done_res, output ready);
endinterface

FILE: design/csv_field_tokenizer.sv
// A result passes through the input register and then the result register.
// Throughput: one byte per cycle unless the output stalls; the input register
// and parser state advance together, and the result register parts the two channels.
// Reset (rst_n low, synchronous): parser state to field start, counts and status
// cleared, fields_per_row back to 1, both channels empty.
// ----------------------------------------------------------------------------
// csv_field_tokenizer
// Splits a CSV byte stream into fields and rows with a per-row field check.
// ----------------------------------------------------------------------------
module csv_field_tokenizer
  import cft_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  cft_in_if.sink           in_chan,
  cft_out_if.source        out_chan,
  input  logic             cfg_we,
  input  logic [15:0]      cfg_wdata
);

  logic [15:0]  fields_per_row_r;
  logic         s1_valid_r;
  logic         s1_func_r;
  logic [7:0]   s1_byte_r;
  parse_state_t state_r;
  parse_state_t state_nxt;
  logic         out_valid_r;
  result_t      out_r;
  result_t      step_res;
  logic         step_emit;
  logic         s1_go;

  cft_step u_step (
    .cur            (state_r),
    .fields_per_row (fields_per_row_r),
    .func           (s1_func_r),
    .data_byte      (s1_byte_r),
    .nxt            (state_nxt),
    .emit           (step_emit),
    .res            (step_res)
  );

  // an item with no result never waits on the output side
  assign s1_go         = s1_valid_r && (!step_emit || !out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fields_per_row_r <= 16'd1;
    end else if (cfg_we) begin
      fields_per_row_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      s1_func_r <= in_chan.func;
      s1_byte_r <= in_chan.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.scan_mode    <= MODE_START;
      state_r.at_row_start <= 1'b1;
      state_r.field_index  <= '0;
      state_r.row_count    <= '0;
      state_r.error_code   <= ST_OK;
    end else if (s1_go) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && step_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && step_emit) begin
      out_r <= step_res;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.has_byte     = out_r.has_byte;
  assign out_chan.out_byte     = out_r.out_byte;
  assign out_chan.field_end    = out_r.field_end;
  assign out_chan.row_end      = out_r.row_end;
  assign out_chan.field_number = out_r.field_number;
  assign out_chan.rows_done    = out_r.rows_done;
  assign out_chan.status       = out_r.status;
  assign out_chan.done_res     = out_r.done_res;

endmodule

FILE: design/cft_step.sv
// ----------------------------------------------------------------------------
// cft_step
// Per-item parser transition: next state and the optional result.
// ----------------------------------------------------------------------------
module cft_step
  import cft_pkg::*;
(
  input  parse_state_t cur,
  input  logic [15:0]  fields_per_row,
  input  logic         func,
  input  logic [7:0]   data_byte,
  output parse_state_t nxt,
  output logic         emit,
  output result_t      res
);

  logic [15:0] eff_fields;
  logic [15:0] last_field;
  logic        comma_ok;
  logic        row_ok;
  status_t     row_err;
  logic [31:0] row_count_inc;
  logic        is_quote;
  logic        is_comma;
  logic        is_nl;

  assign eff_fields    = (fields_per_row == 16'd0) ? 16'd1 : fields_per_row;
  assign last_field    = eff_fields - 16'd1;
  assign comma_ok      = cur.field_index < last_field;
  assign row_ok        = cur.field_index == last_field;
  assign row_err       = comma_ok ? ST_TOO_FEW : ST_TOO_MANY;
  assign row_count_inc = (cur.row_count == ROW_COUNT_MAX) ? cur.row_count
                                                          : cur.row_count + 32'd1;
  assign is_quote      = data_byte == CH_QUOTE;
  assign is_comma      = data_byte == CH_COMMA;
  assign is_nl         = data_byte == CH_NL;

  always_comb begin
    logic ends_field;
    logic pass_byte;
    ends_field = 1'b0;
    pass_byte  = 1'b0;
    nxt  = cur;
    emit = 1'b0;
    res  = '0;

    if (func == FUNC_END) begin
      emit = 1'b1;
      res.done_res = 1'b1;
      if (cur.error_code == ST_OK) begin
        if (cur.scan_mode == MODE_QUOTED) begin
          nxt.error_code = ST_BAD_QUOTE;
        end else if (!(cur.scan_mode == MODE_START && cur.at_row_start)) begin
          if (row_ok) begin
            res.field_end = 1'b1;
            res.row_end   = 1'b1;
            nxt.row_count = row_count_inc;
          end else begin
            nxt.error_code = row_err;
          end
        end
      end
      nxt.scan_mode    = MODE_START;
      nxt.at_row_start = 1'b1;
      nxt.field_index  = '0;
    end else if (cur.error_code == ST_OK) begin
      case (cur.scan_mode)
        MODE_START: begin
          // blank line at row start is skipped quietly
          if (!(is_nl && cur.at_row_start)) begin
            nxt.at_row_start = 1'b0;
            if (is_quote) nxt.scan_mode = MODE_QUOTED;
            else          ends_field = 1'b1;
          end
        end
        MODE_PLAIN: begin
          if (is_quote) begin
            nxt.error_code = ST_BAD_QUOTE;
            emit = 1'b1;
          end else begin
            ends_field = 1'b1;
          end
        end
        MODE_QUOTED: begin
          if (is_quote) nxt.scan_mode = MODE_QSEEN;
          else          pass_byte = 1'b1;
        end
        MODE_QSEEN: begin
          if (is_quote) begin
            // doubled quote gives one literal quote
            nxt.scan_mode = MODE_QUOTED;
            pass_byte = 1'b1;
          end else if (!is_comma && !is_nl) begin
            nxt.error_code = ST_BAD_QUOTE;
            emit = 1'b1;
          end else begin
            ends_field = 1'b1;
          end
        end
        default: ;
      endcase

      // ends_field covers comma, newline and plain data after the mode check
      if (ends_field) begin
        emit = 1'b1;
        if (is_comma) begin
          if (comma_ok) begin
            nxt.field_index = cur.field_index + 16'd1;
            nxt.scan_mode   = MODE_START;
            res.field_end   = 1'b1;
          end else begin
            nxt.error_code = ST_TOO_MANY;
          end
        end else if (is_nl) begin
          if (row_ok) begin
            nxt.row_count    = row_count_inc;
            nxt.field_index  = '0;
            nxt.scan_mode    = MODE_START;
            nxt.at_row_start = 1'b1;
            res.field_end    = 1'b1;
            res.row_end      = 1'b1;
          end else begin
            nxt.error_code = row_err;
          end
        end else begin
          nxt.scan_mode = MODE_PLAIN;
          pass_byte = 1'b1;
        end
      end

      if (pass_byte) begin
        emit = 1'b1;
        res.has_byte = 1'b1;
        res.out_byte = data_byte;
      end
    end

    res.field_number = cur.field_index;
    res.rows_done    = nxt.row_count;
    res.status       = nxt.error_code;
  end

endmodule
